[rtl/vbmt_pkg.sv]
// package: shared constants, types and register codes of the video bus translator
`default_nettype none

package vbmt_pkg;

  // bus map
  localparam int unsigned HEADER_BYTES  = 16;
  localparam int unsigned PATTERN_BYTES = 8192;
  localparam int unsigned NT_DEPTH      = 7936;
  localparam int unsigned PAL_DEPTH     = 32;

  localparam int unsigned PAT_AW   = $clog2(PATTERN_BYTES);
  localparam int unsigned NT_AW    = $clog2(NT_DEPTH);
  localparam int unsigned PAL_AW   = $clog2(PAL_DEPTH);
  localparam int unsigned ROM_AW   = 23;
  localparam int unsigned CFG_IDXW = 3;
  localparam int unsigned CFG_DW   = 8;

  // clearing pass covers the deeper of the two memories
  localparam int unsigned CLR_DEPTH = (PATTERN_BYTES > NT_DEPTH) ? PATTERN_BYTES : NT_DEPTH;
  localparam int unsigned CLR_AW    = $clog2(CLR_DEPTH);

  typedef enum logic [CFG_IDXW-1:0] {
    REG_PATTERN_IS_RAM    = 3'd0,
    REG_MIRRORING_MODE    = 3'd1,
    REG_PROGRAM_BANKS     = 3'd2,
    REG_PATTERN_BANK_LOW  = 3'd3,
    REG_PATTERN_BANK_HIGH = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MIR_NONE = 2'd0,
    MIR_VERT = 2'd1,
    MIR_HORZ = 2'd2
  } mirror_e;

  typedef enum logic [0:0] {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  // which store serves a read
  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_PAT  = 2'd1,
    TGT_NT   = 2'd2,
    TGT_PAL  = 2'd3
  } target_e;

  typedef struct packed {
    logic        command;
    logic [15:0] address;
    logic [7:0]  write_data;
  } vbmt_in_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              from_rom;
    logic [ROM_AW-1:0] rom_address;
  } vbmt_out_t;

  typedef struct packed {
    logic       pattern_is_ram;
    logic [1:0] mirroring_mode;
    logic [7:0] program_banks;
    logic [7:0] pattern_bank_low;
    logic [7:0] pattern_bank_high;
  } vbmt_cfg_t;

  // decoded access for one item
  typedef struct packed {
    target_e           sel;
    logic              pat_we;
    logic              pat_re;
    logic              nt_we;
    logic              nt_re;
    logic              pal_we;
    logic              pal_re;
    logic [PAT_AW-1:0] pat_addr;
    logic [NT_AW-1:0]  nt_addr;
    logic [PAL_AW-1:0] pal_addr;
    logic              from_rom;
    logic [ROM_AW-1:0] rom_address;
  } vbmt_op_t;

endpackage

`default_nettype wire

[rtl/vbmt_ram.sv]
// single-port byte memory with registered read data, no reset on contents
`default_nettype none

module vbmt_ram #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [7:0]    wdata_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/vbmt_decode.sv]
// address decode: bus map, nametable fold and rom address for one item
`default_nettype none

module vbmt_decode
  import vbmt_pkg::*;
#(
  parameter int unsigned HDR_BYTES = HEADER_BYTES
) (
  input  wire vbmt_in_t  item_i,
  input  wire vbmt_cfg_t cfg_i,
  output vbmt_op_t       op_o
);

  logic [13:0]       a;
  logic              wr;
  logic [NT_AW-1:0]  nt_idx;
  logic [NT_AW-1:0]  nt_fold;
  logic [7:0]        bank;
  logic [ROM_AW:0]   rom_sum;

  assign a  = item_i.address[13:0];
  assign wr = (item_i.command == CMD_WRITE);

  // offset from the nametable base, 0x0000..0x1eff
  assign nt_idx = NT_AW'(a - 14'h2000);

  always_comb begin
    nt_fold = nt_idx;
    case (mirror_e'(cfg_i.mirroring_mode))
      MIR_VERT: begin
        if (nt_idx >= NT_AW'('h800) && nt_idx < NT_AW'('h1000)) begin
          nt_fold = nt_idx - NT_AW'('h800);
        end
      end
      MIR_HORZ: begin
        if (nt_idx >= NT_AW'('h400) && nt_idx < NT_AW'('hC00)) begin
          nt_fold = nt_idx - NT_AW'('h400);
        end else if (nt_idx >= NT_AW'('hC00) && nt_idx < NT_AW'('h1000)) begin
          nt_fold = nt_idx - NT_AW'('h800);
        end
      end
      default: begin
        nt_fold = nt_idx;
      end
    endcase
  end

  assign bank = a[12] ? cfg_i.pattern_bank_high : cfg_i.pattern_bank_low;

  // header + banks * 16K + bank * 4K + offset
  assign rom_sum = (ROM_AW+1)'(HDR_BYTES)
                 + (ROM_AW+1)'({cfg_i.program_banks, 14'd0})
                 + (ROM_AW+1)'({bank, 12'd0})
                 + (ROM_AW+1)'(a[11:0]);

  always_comb begin
    op_o             = '0;
    op_o.sel         = TGT_NONE;
    op_o.pat_addr    = a[PAT_AW-1:0];
    op_o.nt_addr     = nt_fold;
    op_o.pal_addr    = a[PAL_AW-1:0];
    if (a < 14'h2000) begin
      if (cfg_i.pattern_is_ram) begin
        op_o.pat_we = wr;
        op_o.pat_re = !wr;
        op_o.sel    = wr ? TGT_NONE : TGT_PAT;
      end else if (!wr) begin
        op_o.from_rom    = 1'b1;
        op_o.rom_address = rom_sum[ROM_AW-1:0];
      end
    end else if (a < 14'h3F00) begin
      op_o.nt_we = wr;
      op_o.nt_re = !wr;
      op_o.sel   = wr ? TGT_NONE : TGT_NT;
    end else begin
      op_o.pal_we = wr;
      op_o.pal_re = !wr;
      op_o.sel    = wr ? TGT_NONE : TGT_PAL;
    end
  end

endmodule

`default_nettype wire

[rtl/video_bus_mirroring_translator.sv]
// top level: video bus address translator with nametable mirroring
`default_nettype none

// channel   | signals                                | payload
// ----------+----------------------------------------+-----------------------------
// in        | in_valid_i / in_ready_o                | in_data_i  (vbmt_in_t)
// out       | out_valid_o / out_ready_i              | out_data_o (vbmt_out_t)
// config    | cfg_we_i, cfg_idx_i, cfg_wdata_i       | write only, no wait
//
// an item passes from acceptance to a valid result through the memory read
// register, then the result register; one item can be accepted every cycle unless the result stalls
// after reset a clearing pass zeroes both memories, one entry per cycle,
// while in_ready_o stays low (config writes still land)
// a stalled result holds in the result register while the read stage keeps
// its item; input is taken while either of the two stages can move
module video_bus_mirroring_translator
  import vbmt_pkg::*;
#(
  parameter int unsigned HDR_BYTES = HEADER_BYTES
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire vbmt_in_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output vbmt_out_t                out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CFG_IDXW-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0]   cfg_wdata_i
);

  // configuration registers
  vbmt_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // pattern area starts as ram, everything else zero
      cfg_q <= '{1'b1, 2'd0, 8'd0, 8'd0, 8'd0};
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PATTERN_IS_RAM:    cfg_q.pattern_is_ram    <= cfg_wdata_i[0];
        REG_MIRRORING_MODE:    cfg_q.mirroring_mode    <= cfg_wdata_i[1:0];
        REG_PROGRAM_BANKS:     cfg_q.program_banks     <= cfg_wdata_i;
        REG_PATTERN_BANK_LOW:  cfg_q.pattern_bank_low  <= cfg_wdata_i;
        REG_PATTERN_BANK_HIGH: cfg_q.pattern_bank_high <= cfg_wdata_i;
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // clearing pass after reset
  logic              clr_busy_q;
  logic [CLR_AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == CLR_AW'(CLR_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // decode straight from the offered item
  vbmt_op_t op;

  vbmt_decode #(
    .HDR_BYTES (HDR_BYTES)
  ) u_decode (
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .op_o   (op)
  );

  // pipeline control
  logic      s1_valid_q;
  target_e   s1_sel_q;
  logic      s1_rom_q;
  logic [ROM_AW-1:0] s1_rom_addr_q;
  logic      out_valid_q;
  vbmt_out_t out_q;
  logic      out_free;
  logic      s1_move;
  logic      accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || out_free);
  assign accept     = in_valid_i && in_ready_o;

  // pattern and nametable memories, shared with the clearing pass
  logic              pat_we;
  logic [PAT_AW-1:0] pat_addr;
  logic [7:0]        pat_wdata;
  logic [7:0]        pat_rdata;
  logic              nt_we;
  logic [NT_AW-1:0]  nt_addr;
  logic [7:0]        nt_wdata;
  logic [7:0]        nt_rdata;

  assign pat_we    = clr_busy_q ? 1'b1 : (accept && op.pat_we);
  assign pat_addr  = clr_busy_q ? clr_cnt_q[PAT_AW-1:0] : op.pat_addr;
  assign pat_wdata = clr_busy_q ? 8'd0 : in_data_i.write_data;

  // nametable is shallower than the sweep: skip entries past its end
  assign nt_we    = clr_busy_q ? (clr_cnt_q < CLR_AW'(NT_DEPTH)) : (accept && op.nt_we);
  assign nt_addr  = clr_busy_q ? clr_cnt_q[NT_AW-1:0] : op.nt_addr;
  assign nt_wdata = clr_busy_q ? 8'd0 : in_data_i.write_data;

  vbmt_ram #(
    .DEPTH (PATTERN_BYTES),
    .AW    (PAT_AW)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .re_i    (accept && op.pat_re),
    .addr_i  (pat_addr),
    .wdata_i (pat_wdata),
    .rdata_o (pat_rdata)
  );

  vbmt_ram #(
    .DEPTH (NT_DEPTH),
    .AW    (NT_AW)
  ) u_nt_ram (
    .clk_i   (clk_i),
    .we_i    (nt_we),
    .re_i    (accept && op.nt_re),
    .addr_i  (nt_addr),
    .wdata_i (nt_wdata),
    .rdata_o (nt_rdata)
  );

  // palette lives in flops, cleared by reset
  logic [7:0] pal_q [PAL_DEPTH];
  logic [7:0] pal_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PAL_DEPTH; i++) begin
        pal_q[i] <= '0;
      end
    end else if (accept && op.pal_we) begin
      pal_q[op.pal_addr] <= in_data_i.write_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && op.pal_re) begin
      pal_rd_q <= pal_q[op.pal_addr];
    end
  end

  // read stage: holds the item while the memory read register settles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sel_q      <= op.sel;
      s1_rom_q      <= op.from_rom;
      s1_rom_addr_q <= op.rom_address;
    end
  end

  // pick the store that served the read; writes and rom reads give zero
  logic [7:0] rd_mux;

  always_comb begin
    case (s1_sel_q)
      TGT_PAT: rd_mux = pat_rdata;
      TGT_NT:  rd_mux = nt_rdata;
      TGT_PAL: rd_mux = pal_rd_q;
      default: rd_mux = 8'd0;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q.read_data   <= rd_mux;
      out_q.from_rom    <= s1_rom_q;
      out_q.rom_address <= s1_rom_addr_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
